>>> sv/shac_pkg.sv
// SHA-256 compression package: word type, initial hash, round constants
// and the round / schedule mixing functions.
// No dependencies; imported by sha256_block_compress_top and by tb.
package shac_pkg;

   typedef logic [31:0] word_type;

   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned HASH_WORDS  = 8;
   localparam int unsigned ROUNDS      = 64;

   localparam logic [3:0] LAST_BLOCK_WORD = 4'd15;
   localparam logic [5:0] LAST_ROUND      = 6'd63;
   localparam logic [2:0] LAST_DIGEST_IDX = 3'd7;

   localparam word_type INIT_HASH [HASH_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Upper-case sigma on a
   function automatic word_type big_sigma0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   // Upper-case sigma on e
   function automatic word_type big_sigma1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   // Schedule sigma on w[t-15]
   function automatic word_type small_sigma0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   // Schedule sigma on w[t-2]
   function automatic word_type small_sigma1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

   function automatic word_type choose(input word_type e, input word_type f,
                                       input word_type g);
      return (e & f) ^ (~e & g);
   endfunction

   function automatic word_type majority(input word_type a, input word_type b,
                                         input word_type c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

endpackage

>>> sv/sha256_block_compress_top.sv
// SHA-256 block compression with chaining: word intake, 64-round engine
// sharing one round datapath, hash update and digest output register.
// Depends on shac_pkg.
//
// After the 16th word of a block, the single round unit does one round per
// cycle over the 64 rounds, then the hash update runs; a final block then
// presents its 8 digest words, one per cycle when rsp_ready is held high.
// No word of the next block is taken until the rounds, the update and any
// digest output are done. Synchronous reset loads the initial hash, clears
// the word count and returns to word intake with no result pending.
module sha256_block_compress_top
   import shac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_message_word,
   input  logic        req_new_message,
   input  logic        req_final_block,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_digest_last
);

   typedef enum logic [1:0] {
      ST_INTAKE,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] word_count_ff, word_count_in;
   logic [5:0] round_ff, round_in;
   logic [2:0] emit_idx_ff, emit_idx_in;
   logic       final_ff, final_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_last_ff, rsp_last_in;
   word_type   rsp_word_ff, rsp_word_in;

   word_type   chain_ff [HASH_WORDS];
   word_type   chain_in [HASH_WORDS];
   word_type   vars_ff  [HASH_WORDS];
   word_type   vars_in  [HASH_WORDS];
   word_type   win_ff   [BLOCK_WORDS];
   word_type   win_in   [BLOCK_WORDS];

   logic       req_xfer;
   word_type   sched_next;
   word_type   x1, x2;

   assign req_ready       = (state_ff == ST_INTAKE);
   assign req_xfer        = req_valid && req_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = rsp_word_ff;
   assign rsp_digest_last = rsp_last_ff;

   // Shared round unit: schedule word 16 ahead and the two round sums
   assign sched_next = small_sigma1(win_ff[14]) + win_ff[9]
                     + small_sigma0(win_ff[1]) + win_ff[0];
   assign x1 = vars_ff[7] + big_sigma1(vars_ff[4])
             + choose(vars_ff[4], vars_ff[5], vars_ff[6])
             + ROUND_K[round_ff] + win_ff[0];
   assign x2 = big_sigma0(vars_ff[0]) + majority(vars_ff[0], vars_ff[1], vars_ff[2]);

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      word_count_in = word_count_ff;
      round_in      = round_ff;
      emit_idx_in   = emit_idx_ff;
      final_in      = final_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_word_in   = rsp_word_ff;
      chain_in      = chain_ff;
      vars_in       = vars_ff;
      win_in        = win_ff;

      unique case (state_ff)
         ST_INTAKE: begin
            if (req_xfer) begin
               // shift the word into the schedule window
               for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                  win_in[i] = win_ff[i + 1];
               end
               win_in[BLOCK_WORDS - 1] = req_message_word;
               if (word_count_ff == '0 && req_new_message) begin
                  chain_in = INIT_HASH;
               end
               word_count_in = word_count_ff + 4'd1;
               if (word_count_ff == LAST_BLOCK_WORD) begin
                  final_in = req_final_block;
                  vars_in  = chain_ff;
                  round_in = '0;
                  state_in = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            win_in[BLOCK_WORDS - 1] = sched_next;
            vars_in[7] = vars_ff[6];
            vars_in[6] = vars_ff[5];
            vars_in[5] = vars_ff[4];
            vars_in[4] = vars_ff[3] + x1;
            vars_in[3] = vars_ff[2];
            vars_in[2] = vars_ff[1];
            vars_in[1] = vars_ff[0];
            vars_in[0] = x1 + x2;
            round_in   = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            for (int j = 0; j < HASH_WORDS; j++) begin
               chain_in[j] = chain_ff[j] + vars_ff[j];
            end
            if (final_ff) begin
               emit_idx_in  = '0;
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b0;
               rsp_word_in  = chain_ff[0] + vars_ff[0];
               state_in     = ST_EMIT;
            end else begin
               state_in = ST_INTAKE;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (rsp_last_ff) begin
                  rsp_valid_in = 1'b0;
                  rsp_last_in  = 1'b0;
                  state_in     = ST_INTAKE;
               end else begin
                  emit_idx_in = emit_idx_ff + 3'd1;
                  rsp_word_in = chain_ff[emit_idx_in];
                  rsp_last_in = (emit_idx_in == LAST_DIGEST_IDX);
               end
            end
         end
         default: begin
            state_in = ST_INTAKE;
         end
      endcase
   end

   // State, datapath and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INTAKE;
         word_count_ff <= '0;
         round_ff      <= '0;
         emit_idx_ff   <= '0;
         final_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
         chain_ff      <= INIT_HASH;
      end else begin
         state_ff      <= state_in;
         word_count_ff <= word_count_in;
         round_ff      <= round_in;
         emit_idx_ff   <= emit_idx_in;
         final_ff      <= final_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_last_ff   <= rsp_last_in;
         chain_ff      <= chain_in;
      end
      rsp_word_ff <= rsp_word_in;
      vars_ff     <= vars_in;
      win_ff      <= win_in;
   end

endmodule

>>> sv/sha256_block_compress_checker.sv
// Port-level checker for sha256_block_compress_top, bound to the top level.
// No package dependency.
module sha256_block_compress_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [31:0] req_message_word,
   input logic        req_new_message,
   input logic        req_final_block,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic        rsp_digest_last
);

   // a waiting word transfer keeps valid and its payload
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_message_word)
                                  && $stable(req_new_message)
                                  && $stable(req_final_block))
      else $error("waiting word changed before transfer");

   // a stalled result transfer holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word)
                                  && $stable(rsp_digest_last))
      else $error("stalled digest word changed");

   // no word intake while a digest is being presented
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("intake open during digest output");

   // the last digest word ends the burst and reopens intake
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_digest_last |=> !rsp_valid && req_ready)
      else $error("digest burst did not end after last word");

   // leaving reset, the block is ready for words with nothing pending
   assert property (@(posedge clock)
      $fell(reset) |-> req_ready && !rsp_valid)
      else $error("bad state after reset");

endmodule

bind sha256_block_compress_top sha256_block_compress_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_message_word (req_message_word),
   .req_new_message  (req_new_message),
   .req_final_block  (req_final_block),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_digest_word  (rsp_digest_word),
   .rsp_digest_last  (rsp_digest_last)
);

>>> sim/tb.sv
// Self-checking testbench for sha256_block_compress_top: SHA-256 compression
// with chaining, checked against a behavioral digest predictor in this file.
// Depends on shac_pkg (word type) and the top-level RTL.
module tb
   import shac_pkg::*;
();

   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 100;
   localparam int MAX_REPORTS  = 10;

   localparam word_type SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct {
      word_type word;
      logic     last;
   } digest_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_message_word = '0;
   logic        req_new_message = 1'b0;
   logic        req_final_block = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic        rsp_digest_last;

   // Predictor state
   word_type         chain_model [8];
   word_type         block_words [16];
   logic [3:0]       word_idx;
   digest_entry_type expected_digest [$];

   // Run control and statistics
   bit send_idle;
   bit sink_stall;
   bit hold_request;
   int hold_left;
   int stall_left;
   int error_count;
   int words_sent;
   int blocks_compressed;
   int digest_words_checked;

   sha256_block_compress_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_message_word (req_message_word),
      .req_new_message  (req_new_message),
      .req_final_block  (req_final_block),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digest_word  (rsp_digest_word),
      .rsp_digest_last  (rsp_digest_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   // Random word with the all-zero and all-one extremes mixed in
   function automatic word_type random_word();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // Run the 64 rounds over the buffered block and fold into the chain
   task automatic compress_block();
      word_type w [64];
      word_type a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int t = 0; t < 16; t++)
         w[t] = block_words[t];
      for (int t = 16; t < 64; t++) begin
         s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      {a, b, c, d, e, f, g, h} = {chain_model[0], chain_model[1], chain_model[2],
                                  chain_model[3], chain_model[4], chain_model[5],
                                  chain_model[6], chain_model[7]};
      for (int t = 0; t < 64; t++) begin
         t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
              + SHA_K[t] + w[t];
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g;
         g = f;
         f = e;
         e = d + t1;
         d = c;
         c = b;
         b = a;
         a = t1 + t2;
      end
      chain_model[0] += a;
      chain_model[1] += b;
      chain_model[2] += c;
      chain_model[3] += d;
      chain_model[4] += e;
      chain_model[5] += f;
      chain_model[6] += g;
      chain_model[7] += h;
      blocks_compressed++;
   endtask

   // Absorb one accepted word; a completed final block queues its digest
   task automatic absorb_word(input word_type w, input logic fresh, input logic fin);
      digest_entry_type ent;
      if (word_idx == 4'd0 && fresh)
         chain_model = SHA_IV;
      block_words[word_idx] = w;
      if (word_idx != 4'd15) begin
         word_idx++;
      end else begin
         word_idx = 4'd0;
         compress_block();
         if (fin) begin
            for (int k = 0; k < 8; k++) begin
               ent.word = chain_model[k];
               ent.last = (k == 7);
               expected_digest.push_back(ent);
            end
         end
      end
   endtask

   function automatic void report_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("ERROR @%0t: %s", $time, msg);
   endfunction

   // Offer one word, wait for the transfer, then update the predictor
   task automatic send_word(input word_type w, input logic fresh, input logic fin);
      int gap;
      gap = (send_idle && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_message_word <= w;
      req_new_message  <= fresh;
      req_final_block  <= fin;
      do @(posedge clock); while (!req_ready);
      absorb_word(w, fresh, fin);
      words_sent++;
   endtask

   // Stop offering words and wait until every expected digest word is seen
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_digest.size() != 0);
   endtask

   // Result sink: random stalls, plus one long hold when requested
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if (sink_stall && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
      end
   end

   // Compare each result transfer with the oldest expected digest word
   always @(posedge clock) begin
      digest_entry_type ent;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_digest.size() == 0) begin
            report_error($sformatf("unexpected digest word %h last=%b",
                                   rsp_digest_word, rsp_digest_last));
         end else begin
            ent = expected_digest.pop_front();
            if (rsp_digest_word !== ent.word)
               report_error($sformatf("digest_word exp %h got %h",
                                      ent.word, rsp_digest_word));
            if (rsp_digest_last !== ent.last)
               report_error($sformatf("digest_last exp %b got %b",
                                      ent.last, rsp_digest_last));
         end
         digest_words_checked++;
      end
   end

   // Known "abc" block with stray flags on middle words, which must be ignored
   task automatic test_known_block();
      word_type w;
      send_idle  = 1'b0;
      sink_stall = 1'b0;
      for (int i = 0; i < 16; i++) begin
         w = (i == 0) ? 32'h6162_6380 : (i == 15) ? 32'h0000_0018 : 32'h0;
         send_word(w, (i == 0) || (i == 5), (i == 15) || (i == 9));
      end
      wait_drained();
   endtask

   // Random messages: mostly fresh starts, some chained, with flag noise
   task automatic test_random_messages(input int word_budget);
      int   start_words;
      int   n_blocks;
      logic fresh;
      logic fin;
      start_words = words_sent;
      while (words_sent - start_words < word_budget) begin
         n_blocks   = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
         send_idle  = ($urandom_range(0, 2) != 0);
         sink_stall = ($urandom_range(0, 2) != 0);
         for (int b = 0; b < n_blocks; b++) begin
            for (int i = 0; i < 16; i++) begin
               if (i == 0)
                  fresh = (b == 0) ? ($urandom_range(0, 4) != 0)
                                   : ($urandom_range(0, 7) == 0);
               else
                  fresh = ($urandom_range(0, 5) == 0);
               if (i == 15)
                  fin = (b == n_blocks - 1) ? 1'b1 : ($urandom_range(0, 9) == 0);
               else
                  fin = ($urandom_range(0, 5) == 0);
               send_word(random_word(), fresh, fin);
            end
         end
      end
      wait_drained();
   endtask

   // Receiver holds off while two final blocks arrive, so the input stalls
   task automatic test_backpressure();
      send_idle    = 1'b0;
      sink_stall   = 1'b0;
      hold_request = 1'b1;
      for (int b = 0; b < 2; b++)
         for (int i = 0; i < 16; i++)
            send_word($urandom, (i == 0) && (b == 0), i == 15);
      wait_drained();
   endtask

   initial begin
      chain_model = SHA_IV;
      word_idx    = 4'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_known_block();
      test_random_messages(80);
      test_backpressure();

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d words in %0d compressed blocks, %0d digest words checked,",
               words_sent, blocks_compressed, digest_words_checked);
      $display("including chained blocks, ignored stray flags and a long receiver hold.");
      if (error_count == 0 && expected_digest.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("%0d mismatches, %0d digest words never seen",
                  error_count, expected_digest.size());
         $display("tb failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Timeout with %0d digest words outstanding", expected_digest.size());
      $display("tb failed");
      $finish;
   end

endmodule
